/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL. Synthesis builds define SYNTH.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* rtl/core/pwba_pkg.sv */
`default_nettype none
package pwba_pkg;

  localparam int OUTPUT_ENTRIES_DEF = 256;
  localparam int FRACTION_BITS_DEF  = 16;

  localparam int VALUE_W  = 32;
  localparam int RAW_W    = 24;
  localparam int INDEX_W  = 8;
  localparam int WSUM_W   = 32;
  localparam int VSUM_W   = 56;
  localparam int MODE_W   = 2;

  // Divide by ten as a multiply by a rounded-up reciprocal; exact for
  // operands below 2^24.
  localparam int          RECIP10_SHIFT = 27;
  localparam logic [23:0] RECIP10       = 24'd13421773;

  localparam logic [MODE_W-1:0] MODE_LEGACY   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REST     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ADDITIVE = 2'd2;

  localparam logic ACTION_CONTRIBUTE = 1'b0;
  localparam logic ACTION_READOUT    = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_C_DIV10,
    S_C_SQUARE,
    S_C_MUL,
    S_C_WRITE,
    S_R_READ,
    S_R_START,
    S_R_DIV,
    S_R_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic clear_wr;
    logic div10;
    logic square;
    logic mul_value;
    logic acc_write;
    logic div_start;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic in_readout;
    logic in_index_ok;
    logic clear_last;
    logic pw_zero;
    logic div_done;
    logic out_free;
  } dp_sts_t;

endpackage
`default_nettype wire

/* rtl/core/pwba_div.sv */
`default_nettype none
module pwba_div import pwba_pkg::*; #(
  parameter int NUM_W = 57,
  parameter int DEN_W = 33
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic      [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [NUM_W-1:0] num_sh;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   trial;
  logic             fits;

  // One restoring step per cycle, most significant quotient bit first.
  assign trial = {rem, num_sh[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem    <= '0;
      num_sh <= num;
      den_q  <= den;
      quot   <= '0;
    end else if (busy) begin
      rem    <= fits ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
      num_sh <= {num_sh[NUM_W-2:0], 1'b0};
      quot   <= {quot[NUM_W-2:0], fits};
    end
  end

endmodule
`default_nettype wire

/* rtl/core/pwba_dp.sv */
`default_nettype none
`include "assert_macros.svh"
module pwba_dp import pwba_pkg::*; #(
  parameter int OUTPUT_ENTRIES = OUTPUT_ENTRIES_DEF,
  parameter int FRACTION_BITS  = FRACTION_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire dp_cmd_t                   cmd,
  output dp_sts_t                        sts,
  input  wire logic                      cfg_write_en,
  input  wire logic [MODE_W-1:0]         cfg_write_data,
  input  wire logic                      action,
  input  wire logic                      channel,
  input  wire logic [INDEX_W-1:0]        output_index,
  input  wire logic signed [RAW_W-1:0]   weight_raw,
  input  wire logic signed [VALUE_W-1:0] subpose_value,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [INDEX_W-1:0]             result_index,
  output logic                           result_channel,
  output logic signed [VALUE_W-1:0]      blended_value
);

  localparam int DEPTH  = 2 * OUTPUT_ENTRIES;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW_W   = FRACTION_BITS + 1;
  localparam int SQ_W   = 2 * PW_W + 1;
  localparam int VW_W   = VALUE_W + PW_W + 1;
  localparam int SUM_W  = VSUM_W + 2;
  localparam int NUM_W  = VSUM_W + 1;
  localparam int DEN_W  = WSUM_W + 1;
  localparam logic [31:0] ONE32 = 32'(1) << FRACTION_BITS;
  localparam logic [PW_W-1:0] ONE_PW = PW_W'(ONE32);
  localparam logic [SQ_W-1:0] HALF_SQ = SQ_W'(ONE32 >> 1);

  logic [WSUM_W-1:0] wsum_mem [DEPTH];
  logic [VSUM_W-1:0] vsum_mem [DEPTH];

  logic [MODE_W-1:0]         mode_sel;
  logic [AW-1:0]             addr;
  logic [AW-1:0]             clr_addr;
  logic                      index_ok;
  logic [INDEX_W-1:0]        index_q;
  logic                      channel_q;
  logic [RAW_W-1:0]          mag;
  logic signed [VALUE_W-1:0] value_q;
  logic [47:0]               prod10;
  logic [PW_W-1:0]           pw;
  logic [2*PW_W-1:0]         sq;
  logic [PW_W-1:0]           w;
  logic signed [VW_W-1:0]    vw;
  logic [WSUM_W-1:0]         wsum_rd;
  logic [VSUM_W-1:0]         vsum_rd;
  logic                      neg;

  logic [31:0]               q10;
  logic [PW_W-1:0]           pw_calc;
  logic [PW_W-1:0]           w_calc;
  logic [WSUM_W:0]           wsum_add;
  logic [WSUM_W-1:0]         wsum_new;
  logic signed [SUM_W-1:0]   vsum_add;
  logic [VSUM_W-1:0]         vsum_new;
  logic [VSUM_W-1:0]         num_mag;
  logic [DEN_W-1:0]          den_sel;
  logic                      force_zero;
  logic                      div_done;
  logic [NUM_W-1:0]          quot;
  logic [VALUE_W-1:0]        blend_sat;
  logic [AW-1:0]             in_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_sel <= MODE_ADDITIVE;
    end else if (cfg_write_en) begin
      mode_sel <= cfg_write_data;
    end
  end

  assign in_addr = channel ? AW'(OUTPUT_ENTRIES) + AW'(output_index) : AW'(output_index);

  assign sts.in_readout  = (action == ACTION_READOUT);
  assign sts.in_index_ok = 32'(output_index) < 32'(OUTPUT_ENTRIES);
  assign sts.clear_last  = (clr_addr == AW'(DEPTH - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_wr) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr      <= in_addr;
      index_ok  <= sts.in_index_ok;
      index_q   <= output_index;
      channel_q <= channel;
      mag       <= weight_raw[RAW_W-1] ? RAW_W'(-weight_raw)
                                       : RAW_W'(weight_raw);
      value_q   <= subpose_value;
    end
  end

  // Memory: one write port, one registered read port at the item's address.
  always_ff @(posedge clk) begin
    wsum_rd <= wsum_mem[addr];
    vsum_rd <= vsum_mem[addr];
    if (cmd.clear_wr) begin
      wsum_mem[clr_addr] <= '0;
      vsum_mem[clr_addr] <= '0;
    end else if (cmd.acc_write) begin
      wsum_mem[addr] <= wsum_new;
      vsum_mem[addr] <= vsum_new;
    end else if (cmd.div_start) begin
      wsum_mem[addr] <= '0;
      vsum_mem[addr] <= '0;
    end
  end

  // Pose weight: round(|raw| / 10), limited to one.
  assign q10     = 32'(prod10 >> RECIP10_SHIFT);
  assign pw_calc = (q10 >= ONE32) ? ONE_PW : PW_W'(q10);
  assign sts.pw_zero = (pw_calc == '0);
  assign w_calc  = (mode_sel == MODE_ADDITIVE) ? pw
                 : PW_W'((SQ_W'(sq) + HALF_SQ) >> FRACTION_BITS);

  always_ff @(posedge clk) begin
    if (cmd.div10) begin
      prod10 <= 48'(mag + RAW_W'(5)) * 48'(RECIP10);
    end
    if (cmd.square) begin
      pw <= pw_calc;
      sq <= pw_calc * pw_calc;
    end
    if (cmd.mul_value) begin
      w  <= w_calc;
      vw <= VW_W'(value_q) * $signed({1'b0, w_calc});
    end
  end

  assign wsum_add = {1'b0, wsum_rd} + (WSUM_W + 1)'(w);
  assign wsum_new = wsum_add[WSUM_W] ? '1 : wsum_add[WSUM_W-1:0];
  assign vsum_add = SUM_W'($signed(vsum_rd)) + SUM_W'(vw);

  always_comb begin
    if (vsum_add > $signed(SUM_W'({1'b0, {(VSUM_W-1){1'b1}}}))) begin
      vsum_new = {1'b0, {(VSUM_W-1){1'b1}}};
    end else if (vsum_add < -$signed(SUM_W'({1'b1, {(VSUM_W-1){1'b0}}}))) begin
      vsum_new = {1'b1, {(VSUM_W-1){1'b0}}};
    end else begin
      vsum_new = vsum_add[VSUM_W-1:0];
    end
  end

  // Read-out operands: magnitude of the weighted sum and the mode's divisor.
  assign num_mag = vsum_rd[VSUM_W-1] ? VSUM_W'(-$signed(vsum_rd)) : vsum_rd;

  always_comb begin
    force_zero = 1'b0;
    case (mode_sel)
      MODE_LEGACY: begin
        // An empty weight sum divides by one so that the zero result holds.
        den_sel    = (wsum_rd == '0) ? DEN_W'(1) : {1'b0, wsum_rd};
        force_zero = (wsum_rd == '0);
      end
      MODE_REST:     den_sel = DEN_W'(ONE32) + {1'b0, wsum_rd};
      MODE_ADDITIVE: den_sel = DEN_W'(ONE32);
      default: begin
        den_sel    = DEN_W'(1);
        force_zero = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      neg <= vsum_rd[VSUM_W-1];
    end
  end

  pwba_div #(
    .NUM_W(NUM_W),
    .DEN_W(DEN_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.div_start),
    .num  (force_zero ? '0 : NUM_W'(num_mag) + NUM_W'(den_sel >> 1)),
    .den  (den_sel),
    .done (div_done),
    .quot (quot)
  );

  assign sts.div_done = div_done;

  always_comb begin
    if (!neg) begin
      blend_sat = (quot > NUM_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : quot[VALUE_W-1:0];
    end else begin
      blend_sat = (quot > NUM_W'(32'h8000_0000)) ? 32'h8000_0000
                                                : VALUE_W'(-quot[VALUE_W-1:0]);
    end
  end

  assign sts.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result_index   <= index_q;
      result_channel <= channel_q;
      blended_value  <= index_ok ? $signed(blend_sat) : '0;
    end
  end

  `ASSERT_IMPLIES(a_no_overwrite, cmd.out_load, !(out_valid && out_stall))
  `ASSERT_IMPLIES(a_acc_nonzero_pw, cmd.acc_write, pw != '0)
  `ASSERT_IMPLIES(a_div_valid_index, cmd.div_start, index_ok)

endmodule
`default_nettype wire

/* rtl/core/pwba_ctrl.sv */
`default_nettype none
module pwba_ctrl import pwba_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_stall,
  output dp_cmd_t      cmd,
  input  wire dp_sts_t sts
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (sts.in_readout) begin
            state_next = sts.in_index_ok ? S_R_READ : S_R_EMIT;
          end else if (sts.in_index_ok) begin
            state_next = S_C_DIV10;
          end
        end
      end
      S_C_DIV10: begin
        cmd.div10  = 1'b1;
        state_next = S_C_SQUARE;
      end
      S_C_SQUARE: begin
        cmd.square = 1'b1;
        state_next = sts.pw_zero ? S_IDLE : S_C_MUL;
      end
      S_C_MUL: begin
        cmd.mul_value = 1'b1;
        state_next    = S_C_WRITE;
      end
      S_C_WRITE: begin
        cmd.acc_write = 1'b1;
        state_next    = S_IDLE;
      end
      S_R_READ:  state_next = S_R_START;
      S_R_START: begin
        cmd.div_start = 1'b1;
        state_next    = S_R_DIV;
      end
      S_R_DIV: begin
        if (sts.div_done) begin
          state_next = S_R_EMIT;
        end
      end
      S_R_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/core/pose_weighted_blend_accumulator.sv */
// Pose weighted blend accumulator.
// Input channel (in_valid / in_stall): each item either contributes a
// weighted subpose value to one linear or angular accumulator entry, or
// reads out that entry's blend under the mode register and clears it. Only
// read-out items produce a result item on the output channel
// (out_valid / out_stall), carrying the index, channel and blended value.
// A contribution steps through the reciprocal divide by ten, weight square,
// value multiply and memory write before the next item is taken; one with
// a zero pose weight returns to idle after the square. A read-out steps
// through the memory read, the divider start and the restoring divide,
// which retires one quotient bit per cycle over 57 bits, then loads its
// result register and returns to idle for the next item; a read-out of an
// index beyond the entry count goes straight to that load, with zero as
// its value. After reset the block clears both accumulator memories, all
// 2 * OUTPUT_ENTRIES entries, one entry per cycle, holding in_stall high;
// the mode resets to additive and may be written through cfg_write_en at
// any time the block is idle. A result waiting under out_stall is held in
// the output register while the next items are accepted; a later read-out
// waits in its last step until that register is free.
`default_nettype none
module pose_weighted_blend_accumulator import pwba_pkg::*; #(
  parameter int OUTPUT_ENTRIES = OUTPUT_ENTRIES_DEF,
  parameter int FRACTION_BITS  = FRACTION_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_write_en,
  input  wire logic [MODE_W-1:0]         cfg_write_data,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic                      action,
  input  wire logic                      channel,
  input  wire logic [INDEX_W-1:0]        output_index,
  input  wire logic signed [RAW_W-1:0]   weight_raw,
  input  wire logic signed [VALUE_W-1:0] subpose_value,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [INDEX_W-1:0]             result_index,
  output logic                           result_channel,
  output logic signed [VALUE_W-1:0]      blended_value
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // The controller sequences each item; the datapath holds the memories,
  // arithmetic, divider and the output register.
  pwba_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cmd     (cmd),
    .sts     (sts)
  );

  pwba_dp #(
    .OUTPUT_ENTRIES(OUTPUT_ENTRIES),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .action         (action),
    .channel        (channel),
    .output_index   (output_index),
    .weight_raw     (weight_raw),
    .subpose_value  (subpose_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .result_index   (result_index),
    .result_channel (result_channel),
    .blended_value  (blended_value)
  );

endmodule
`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import pwba_pkg::*;

  // The mode code that the block does not define: read-outs return zero.
  localparam logic [MODE_W-1:0] MODE_UNDEFINED = 2'd3;
  localparam int ENTRIES = OUTPUT_ENTRIES_DEF;
  localparam longint unsigned FX_ONE = 64'd1 << FRACTION_BITS_DEF;
  localparam longint WSUM_CAP = 64'hFFFF_FFFF;
  localparam longint VSUM_HI = (64'sd1 <<< 55) - 1;
  localparam longint VSUM_LO = -(64'sd1 <<< 55);

  logic clk = 1'b0;
  logic rst;
  logic cfg_write_en;
  logic [MODE_W-1:0] cfg_write_data;
  logic in_valid;
  logic in_stall;
  logic action;
  logic channel;
  logic [INDEX_W-1:0] output_index;
  logic signed [RAW_W-1:0] weight_raw;
  logic signed [VALUE_W-1:0] subpose_value;
  logic out_valid;
  logic out_stall;
  logic [INDEX_W-1:0] result_index;
  logic result_channel;
  logic signed [VALUE_W-1:0] blended_value;

  pose_weighted_blend_accumulator i_dut (
    .clk(clk), .rst(rst),
    .cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .channel(channel), .output_index(output_index),
    .weight_raw(weight_raw), .subpose_value(subpose_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_index(result_index), .result_channel(result_channel),
    .blended_value(blended_value)
  );

  always #2 clk = ~clk;

  // One blended read-out, as the output channel should carry it.
  typedef struct {
    logic [INDEX_W-1:0] idx;
    logic ch;
    logic signed [VALUE_W-1:0] value;
  } blend_t;

  // Shadow copy of the block: mode register and both accumulator banks.
  logic [MODE_W-1:0] mode_shadow;
  longint unsigned weight_sums [2*ENTRIES];
  longint value_sums [2*ENTRIES];
  blend_t pending_blends[$];
  int errors = 0;
  bit quiet = 1'b0;  // When set, neither side inserts idle cycles.

  // Division of a signed sum by a positive divisor, rounded to nearest
  // with ties away from zero, then clipped to the 32-bit result range.
  function automatic logic signed [31:0] round_div(longint n, longint unsigned d);
    bit neg;
    longint unsigned mag, q;
    neg = n < 0;
    mag = neg ? longint'(-n) : longint'(n);
    q = (mag + d / 2) / d;
    if (neg) return (q > 64'h8000_0000) ? 32'sh8000_0000 : -q[31:0];
    return (q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : q[31:0];
  endfunction

  // Applies one accepted item to the shadow state. Returns 1 and fills
  // the blend when the item is a read-out.
  function automatic bit predict_item(logic act, logic ch, logic [7:0] idx,
                                      logic signed [23:0] raw, logic signed [31:0] val,
                                      output blend_t blend);
    int e;
    longint mag, sum;
    longint unsigned pw, w, ws, sw;
    e = ch * ENTRIES + idx;
    blend.idx = idx;
    blend.ch = ch;
    blend.value = '0;
    if (act == ACTION_CONTRIBUTE) begin
      mag = (raw < 0) ? -longint'(raw) : longint'(raw);
      pw = (mag + 5) / 10;
      if (pw > FX_ONE) pw = FX_ONE;
      // A weight that rounds to zero leaves the entry alone.
      if (pw == 0) return 1'b0;
      w = (mode_shadow == MODE_ADDITIVE) ? pw : ((pw * pw + FX_ONE / 2) >> FRACTION_BITS_DEF);
      ws = weight_sums[e] + w;
      weight_sums[e] = (ws > WSUM_CAP) ? WSUM_CAP : ws;
      sum = value_sums[e] + longint'(val) * longint'(w);
      if (sum > VSUM_HI) sum = VSUM_HI;
      if (sum < VSUM_LO) sum = VSUM_LO;
      value_sums[e] = sum;
      return 1'b0;
    end
    sw = weight_sums[e];
    case (mode_shadow)
      MODE_LEGACY: blend.value = (sw == 0) ? 32'sd0 : round_div(value_sums[e], sw);
      MODE_REST: blend.value = round_div(value_sums[e], FX_ONE + sw);
      MODE_ADDITIVE: blend.value = round_div(value_sums[e], FX_ONE);
      default: blend.value = '0;
    endcase
    weight_sums[e] = 0;
    value_sums[e] = 0;
    return 1'b1;
  endfunction

  // Presents one item after a random gap and waits until it is taken.
  // Called and returns at a rising edge. A read-out whose value is known
  // up front passes it in fixed_value.
  task automatic send_item(logic act, logic ch, logic [7:0] idx, logic signed [23:0] raw,
                           logic signed [31:0] val, bit has_fixed = 1'b0,
                           logic signed [31:0] fixed_value = '0);
    int gap;
    blend_t blend;
    gap = quiet ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    channel <= ch;
    output_index <= idx;
    weight_raw <= raw;
    subpose_value <= val;
    do @(posedge clk); while (in_stall);
    if (predict_item(act, ch, idx, raw, val, blend)) begin
      if (has_fixed) blend.value = fixed_value;
      pending_blends.insert(pending_blends.size(), blend);
    end
  endtask

  // Mode writes happen only with the block drained; the pause covers a
  // contribution still working through its four steps.
  task automatic write_mode(logic [MODE_W-1:0] m);
    in_valid <= 1'b0;
    wait (pending_blends.size() == 0);
    @(posedge clk);
    repeat (12) @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_write_data <= m;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    mode_shadow = m;
  endtask

  // Random item. Most traffic hits a handful of entries so that sums build
  // up before a read-out; weights cover tiny, clamped and arbitrary values.
  task automatic send_random();
    logic act, ch;
    logic [7:0] idx;
    logic signed [23:0] raw;
    logic signed [31:0] val;
    act = ($urandom_range(0, 3) == 0) ? ACTION_READOUT : ACTION_CONTRIBUTE;
    ch = 1'($urandom_range(0, 1));
    idx = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));
    case ($urandom_range(0, 2))
      0: raw = 24'($urandom);
      1: raw = 24'($urandom_range(0, 40));
      default: raw = 24'($urandom_range(600000, 8388607));
    endcase
    if ($urandom_range(0, 1)) raw = -raw;
    val = ($urandom_range(0, 4) == 0) ? ($urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000)
                                       : 32'($urandom);
    send_item(act, ch, idx, raw, val);
  endtask

  // Result side: random stall per item, checked against the oldest
  // expected blend at the edge where the item is taken.
  initial begin
    int hold;
    blend_t want;
    out_stall <= 1'b1;
    @(negedge rst);
    @(posedge clk);
    forever begin
      hold = quiet ? 0 : $urandom_range(0, 18);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      if (pending_blends.size() == 0) begin
        $display("%0t: unexpected result index %0d channel %0d value %0d", $time,
                 result_index, result_channel, blended_value);
        errors++;
      end else begin
        want = pending_blends.pop_front();
        if (result_index !== want.idx) begin
          $display("%0t: result_index expected %0d actual %0d", $time, want.idx, result_index);
          errors++;
        end
        if (result_channel !== want.ch) begin
          $display("%0t: result_channel expected %0d actual %0d", $time, want.ch,
                   result_channel);
          errors++;
        end
        if (blended_value !== want.value) begin
          $display("%0t: blended_value expected %0d actual %0d", $time, want.value,
                   blended_value);
          errors++;
        end
      end
    end
  end

  // Directed items. Typed values are the obvious ones: fresh entries read
  // zero, and a full weight in additive mode returns the value itself.
  typedef struct {
    logic act;
    logic ch;
    logic [7:0] idx;
    logic signed [23:0] raw;
    logic signed [31:0] val;
    bit typed;
    logic signed [31:0] want;
  } row_t;

  row_t rows [] = '{
    '{ACTION_READOUT, 1'b0, 8'd0, 24'sd0, 32'sd0, 1'b1, 32'sd0},
    '{ACTION_READOUT, 1'b1, 8'd255, 24'sd0, 32'sd0, 1'b1, 32'sd0},
    '{ACTION_CONTRIBUTE, 1'b0, 8'd0, 24'sd655360, 32'sh7FFF_FFFF, 1'b0, 32'sd0},
    '{ACTION_READOUT, 1'b0, 8'd0, 24'sh7FFFFF, 32'sh7FFF_FFFF, 1'b1, 32'sh7FFF_FFFF},
    '{ACTION_CONTRIBUTE, 1'b1, 8'd255, 24'sh800000, 32'sh8000_0000, 1'b0, 32'sd0},
    '{ACTION_READOUT, 1'b1, 8'd255, 24'sh800000, 32'sh8000_0000, 1'b1, 32'sh8000_0000},
    '{ACTION_CONTRIBUTE, 1'b0, 8'd7, 24'sd4, 32'sd65536, 1'b0, 32'sd0},
    '{ACTION_READOUT, 1'b0, 8'd7, 24'sd0, 32'sd0, 1'b1, 32'sd0},
    '{ACTION_CONTRIBUTE, 1'b0, 8'd8, 24'sd5, 32'sd65536, 1'b0, 32'sd0},
    '{ACTION_CONTRIBUTE, 1'b0, 8'd8, -24'sd5, -32'sd65536, 1'b0, 32'sd0},
    '{ACTION_CONTRIBUTE, 1'b0, 8'd8, 24'sh7FFFFF, 32'sh1234_5678, 1'b0, 32'sd0},
    '{ACTION_READOUT, 1'b0, 8'd8, 24'sh555555, 32'shAAAA_AAAA, 1'b0, 32'sd0},
    '{ACTION_CONTRIBUTE, 1'b1, 8'd170, 24'sd327680, -32'sd1, 1'b0, 32'sd0},
    '{ACTION_CONTRIBUTE, 1'b1, 8'd170, -24'sd98304, 32'sh5555_5555, 1'b0, 32'sd0},
    '{ACTION_READOUT, 1'b1, 8'd170, 24'sd0, 32'sd0, 1'b0, 32'sd0},
    '{ACTION_CONTRIBUTE, 1'b0, 8'd85, 24'sd15, 32'sd3, 1'b0, 32'sd0},
    '{ACTION_READOUT, 1'b0, 8'd85, 24'sd0, 32'sd0, 1'b0, 32'sd0}
  };

  // Modes visited by the random phases, the undefined code among them.
  logic [MODE_W-1:0] phase_modes [] = '{MODE_LEGACY, MODE_REST, MODE_UNDEFINED,
                                        MODE_ADDITIVE, MODE_LEGACY, MODE_REST};

  initial begin
    rst <= 1'b1;
    cfg_write_en <= 1'b0;
    cfg_write_data <= '0;
    in_valid <= 1'b0;
    action <= ACTION_CONTRIBUTE;
    channel <= 1'b0;
    output_index <= '0;
    weight_raw <= '0;
    subpose_value <= '0;
    mode_shadow = MODE_ADDITIVE;
    foreach (weight_sums[i]) weight_sums[i] = 0;
    foreach (value_sums[i]) value_sums[i] = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // The directed rows assume the reset mode, which is additive.
    foreach (rows[i])
      send_item(rows[i].act, rows[i].ch, rows[i].idx, rows[i].raw, rows[i].val,
                rows[i].typed, rows[i].want);

    foreach (phase_modes[p]) begin
      write_mode(phase_modes[p]);
      for (int n = 0; n < 100; n++) begin
        quiet = ((n / 25) % 4) == 2;
        send_random();
      end
      quiet = 1'b0;
      // Drain entries 0 to 5 of both channels so each mode ends with read-outs.
      for (int c = 0; c < 2; c++)
        for (int k = 0; k < 6; k++)
          send_item(ACTION_READOUT, c[0], 8'(k), 24'($urandom), 32'($urandom));
    end
    in_valid <= 1'b0;
    wait (pending_blends.size() == 0);
    repeat (80) @(posedge clk);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("testbench: errors");
    $finish;
  end

endmodule
`default_nettype wire
